// ----- hdl/crf_pkg.sv -----
// ============================================================================
// crf_pkg: shared types and constants of the rectangle fill stream unit
// Beat formats, display geometry, command codes and the header sequence.
// ============================================================================
`default_nettype none

package crf_pkg;

  // Screen geometry.
  localparam int DISPLAY_WIDTH  = 480;
  localparam int DISPLAY_HEIGHT = 320;
  localparam int MAX_DIM        = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ?
                                  DISPLAY_WIDTH : DISPLAY_HEIGHT;
  // Bits needed for a column or row index (0 .. MAX_DIM-1).
  localparam int COORD_W        = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH    = 4;

  // Operation codes of an input beat.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Display command bytes.
  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

  // Input beat.
  typedef struct packed {
    logic               operation;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        [15:0] fill_color;
  } crf_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_of_transfer;
    logic       last;
  } crf_out_t;

  // Classified entry handed from the front to the back.
  typedef struct packed {
    logic               is_start;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] bottom_row;
    logic [23:0]        pixel_bytes;
  } crf_cmd_t;

  // Position in the byte stream of one fill.
  typedef enum logic [3:0] {
    ST_COL_CMD,
    ST_COL_FIRST_HI,
    ST_COL_FIRST_LO,
    ST_COL_LAST_HI,
    ST_COL_LAST_LO,
    ST_ROW_CMD,
    ST_ROW_FIRST_HI,
    ST_ROW_FIRST_LO,
    ST_ROW_LAST_HI,
    ST_ROW_LAST_LO,
    ST_MEM_CMD,
    ST_PIXELS
  } crf_step_e;

endpackage

`default_nettype wire

// ----- hdl/crf_front.sv -----
// ============================================================================
// crf_front: input handshake, clipping and colour expansion
// Accepts input beats, drops empty fill commands and queues the rest.
// ============================================================================
`default_nettype none

module crf_front import crf_pkg::*; (
  input  wire crf_in_t  in_beat_i,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire           queue_full_i,
  output logic          push_o,
  output crf_cmd_t      push_cmd_o
);

  localparam logic signed [17:0] DispW = 18'(DISPLAY_WIDTH);
  localparam logic signed [17:0] DispH = 18'(DISPLAY_HEIGHT);

  logic signed [17:0] x_s, y_s, w_s, h_s;
  logic signed [17:0] x_end, y_end;
  logic signed [17:0] left_s, top_s, right_excl, bottom_excl;
  logic signed [17:0] right_s, bottom_s;
  logic               size_bad, clip_empty, keep;
  logic [4:0]         red5, blue5;
  logic [5:0]         green6;

  always_comb begin
    x_s = $signed({{2{in_beat_i.rect_x[15]}}, in_beat_i.rect_x});
    y_s = $signed({{2{in_beat_i.rect_y[15]}}, in_beat_i.rect_y});
    w_s = $signed({{2{in_beat_i.rect_w[15]}}, in_beat_i.rect_w});
    h_s = $signed({{2{in_beat_i.rect_h[15]}}, in_beat_i.rect_h});

    x_end = x_s + w_s;
    y_end = y_s + h_s;

    // Clipped span is [max(x, 0), min(x + w, width)).
    left_s      = x_s[17] ? 18'sd0 : x_s;
    top_s       = y_s[17] ? 18'sd0 : y_s;
    right_excl  = (x_end > DispW) ? DispW : x_end;
    bottom_excl = (y_end > DispH) ? DispH : y_end;
    right_s     = right_excl - 18'sd1;
    bottom_s    = bottom_excl - 18'sd1;

    size_bad   = (w_s <= 18'sd0) || (h_s <= 18'sd0);
    clip_empty = (right_excl <= left_s) || (bottom_excl <= top_s);

    keep = (in_beat_i.operation == OP_TICK) || !(size_bad || clip_empty);
  end

  // Widen each colour channel to eight bits by repeating its top bits.
  assign red5   = in_beat_i.fill_color[15:11];
  assign green6 = in_beat_i.fill_color[10:5];
  assign blue5  = in_beat_i.fill_color[4:0];

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o && keep;

  always_comb begin
    push_cmd_o.is_start    = (in_beat_i.operation == OP_START);
    push_cmd_o.left_col    = left_s[COORD_W-1:0];
    push_cmd_o.right_col   = right_s[COORD_W-1:0];
    push_cmd_o.top_row     = top_s[COORD_W-1:0];
    push_cmd_o.bottom_row  = bottom_s[COORD_W-1:0];
    push_cmd_o.pixel_bytes = {red5, red5[4:2], green6, green6[5:4], blue5, blue5[4:2]};
  end

endmodule

`default_nettype wire

// ----- hdl/crf_queue.sv -----
// ============================================================================
// crf_queue: short queue between the front and the back
// A small circular buffer of classified entries with a fill count.
// ============================================================================
`default_nettype none

module crf_queue import crf_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wire crf_cmd_t  push_cmd_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           head_valid_o,
  output crf_cmd_t       head_cmd_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  crf_cmd_t        slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = slots_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crf_back.sv -----
// ============================================================================
// crf_back: fill sequencer and output register
// Runs the header and pixel byte sequence, one byte per tick entry.
// ============================================================================
`default_nettype none

module crf_back import crf_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            head_valid_i,
  input  wire crf_cmd_t  head_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output crf_out_t       out_beat_o
);

  crf_step_e          step_q, step_d;
  logic               busy_q, busy_d;
  logic [1:0]         byte_q, byte_d;
  logic [COORD_W-1:0] left_q, left_d, right_q, right_d;
  logic [COORD_W-1:0] top_q, top_d, bottom_q, bottom_d;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [23:0]        pix_q, pix_d;
  logic               out_valid_q, out_valid_d;
  crf_out_t           out_q, out_d;
  logic               slot_free, emit;
  logic [15:0]        left_w, right_w, top_w, bottom_w;

  assign left_w   = {{(16 - COORD_W){1'b0}}, left_q};
  assign right_w  = {{(16 - COORD_W){1'b0}}, right_q};
  assign top_w    = {{(16 - COORD_W){1'b0}}, top_q};
  assign bottom_w = {{(16 - COORD_W){1'b0}}, bottom_q};

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = head_valid_i && !head_cmd_i.is_start && busy_q && slot_free;
  assign pop_o     = head_valid_i && (head_cmd_i.is_start || !busy_q || slot_free);

  always_comb begin
    step_d      = step_q;
    busy_d      = busy_q;
    byte_d      = byte_q;
    left_d      = left_q;
    right_d     = right_q;
    top_d       = top_q;
    bottom_d    = bottom_q;
    col_d       = col_q;
    row_d       = row_q;
    pix_d       = pix_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    // A start only takes effect while idle.
    if (head_valid_i && head_cmd_i.is_start && !busy_q) begin
      left_d   = head_cmd_i.left_col;
      right_d  = head_cmd_i.right_col;
      top_d    = head_cmd_i.top_row;
      bottom_d = head_cmd_i.bottom_row;
      col_d    = head_cmd_i.left_col;
      row_d    = head_cmd_i.top_row;
      pix_d    = head_cmd_i.pixel_bytes;
      byte_d   = 2'd0;
      step_d   = ST_COL_CMD;
      busy_d   = 1'b1;
    end

    if (emit) begin
      out_valid_d           = 1'b1;
      out_d.is_data         = 1'b1;
      out_d.end_of_transfer = 1'b0;
      out_d.last            = 1'b0;
      out_d.out_byte        = 8'h00;
      case (step_q)
        ST_COL_CMD: begin
          out_d.out_byte        = CMD_COL_ADDR;
          out_d.is_data         = 1'b0;
          out_d.end_of_transfer = 1'b1;
          step_d                = ST_COL_FIRST_HI;
        end
        ST_COL_FIRST_HI: begin
          out_d.out_byte = left_w[15:8];
          step_d         = ST_COL_FIRST_LO;
        end
        ST_COL_FIRST_LO: begin
          out_d.out_byte = left_w[7:0];
          step_d         = ST_COL_LAST_HI;
        end
        ST_COL_LAST_HI: begin
          out_d.out_byte = right_w[15:8];
          step_d         = ST_COL_LAST_LO;
        end
        ST_COL_LAST_LO: begin
          out_d.out_byte        = right_w[7:0];
          out_d.end_of_transfer = 1'b1;
          step_d                = ST_ROW_CMD;
        end
        ST_ROW_CMD: begin
          out_d.out_byte        = CMD_ROW_ADDR;
          out_d.is_data         = 1'b0;
          out_d.end_of_transfer = 1'b1;
          step_d                = ST_ROW_FIRST_HI;
        end
        ST_ROW_FIRST_HI: begin
          out_d.out_byte = top_w[15:8];
          step_d         = ST_ROW_FIRST_LO;
        end
        ST_ROW_FIRST_LO: begin
          out_d.out_byte = top_w[7:0];
          step_d         = ST_ROW_LAST_HI;
        end
        ST_ROW_LAST_HI: begin
          out_d.out_byte = bottom_w[15:8];
          step_d         = ST_ROW_LAST_LO;
        end
        ST_ROW_LAST_LO: begin
          out_d.out_byte        = bottom_w[7:0];
          out_d.end_of_transfer = 1'b1;
          step_d                = ST_MEM_CMD;
        end
        ST_MEM_CMD: begin
          out_d.out_byte        = CMD_MEM_WR;
          out_d.is_data         = 1'b0;
          out_d.end_of_transfer = 1'b1;
          step_d                = ST_PIXELS;
        end
        ST_PIXELS: begin
          case (byte_q)
            2'd0:    out_d.out_byte = pix_q[23:16];
            2'd1:    out_d.out_byte = pix_q[15:8];
            2'd2:    out_d.out_byte = pix_q[7:0];
            default: out_d.out_byte = 8'h00;
          endcase
          if (byte_q >= 2'd2) begin
            byte_d = 2'd0;
            if (col_q >= right_q) begin
              col_d = left_q;
              if (row_q >= bottom_q) begin
                out_d.end_of_transfer = 1'b1;
                out_d.last            = 1'b1;
                busy_d                = 1'b0;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end else begin
            byte_d = byte_q + 1'b1;
          end
        end
        default: begin
          step_d = ST_PIXELS;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_COL_CMD;
      busy_q      <= 1'b0;
      byte_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    right_q  <= right_d;
    top_q    <= top_d;
    bottom_q <= bottom_d;
    col_q    <= col_d;
    row_q    <= row_d;
    pix_q    <= pix_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/clipped_rect_fill_stream_unit.sv -----
// ============================================================================
// clipped_rect_fill_stream_unit: clipped rectangle fill byte stream
// Turns fill commands into the command, address and pixel byte stream.
// ============================================================================
// Usage. The input channel (in_valid_i, in_ready_o, in_beat_i) carries two
// kinds of beat. A start beat holds a rectangle and an RGB565 colour; it
// never produces output. The rectangle is clipped to the screen in the front
// stage, and a command that leaves nothing on screen is discarded there. A
// tick beat asks for the next display byte. While a fill runs, every tick
// yields exactly one output beat (out_valid_o, out_ready_i, out_beat_o):
// the column address command and its four bytes, the row address command
// and its four bytes, the memory write command, then red, green and blue for
// every pixel. A tick while idle and a start while busy produce nothing.
// A tick accepted at the input is written into the four entry queue; once it
// reaches the head and the output register is free, its byte is loaded into
// the output register.
// Throughput is one beat per cycle on both sides, set by the back sequencer,
// which retires one queue entry each cycle while the output register drains.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_ready_o falls once all four entries are taken. Reset empties
// the queue and the output register and leaves the engine idle.
// ============================================================================
`default_nettype none

module clipped_rect_fill_stream_unit import crf_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire crf_in_t  in_beat_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output crf_out_t      out_beat_o
);

  logic     push, queue_full, pop, head_valid;
  crf_cmd_t push_cmd, head_cmd;

  // Front: handshake, classification and clipping.
  crf_front u_front (
    .in_beat_i    (in_beat_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  // Queue decouples the front from the sequencer.
  crf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // Back: fill state and output register.
  crf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

`default_nettype wire

// ----- hdl/crf_checker.sv -----
// ============================================================================
// crf_checker: port level checks of the rectangle fill stream unit
// Input and output handshake and byte stream framing rules, bound to the top level.
// ============================================================================
`default_nettype none

module crf_checker import crf_pkg::*; (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input wire crf_in_t  in_beat_i,
  input wire           out_valid_o,
  input wire           out_ready_i,
  input wire crf_out_t out_beat_o
);

  // A waiting input beat stays offered and unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_beat_i))
    else $error("waiting input beat changed");

  // A stalled output beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  // Command bytes are always one of the three display commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.is_data |->
      out_beat_o.out_byte == CMD_COL_ADDR || out_beat_o.out_byte == CMD_ROW_ADDR ||
      out_beat_o.out_byte == CMD_MEM_WR)
    else $error("unknown command byte");

  // Every command byte closes its own transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.is_data |-> out_beat_o.end_of_transfer)
    else $error("command byte without end of transfer");

  // The final byte of a fill is a pixel byte that ends the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.last |-> out_beat_o.is_data && out_beat_o.end_of_transfer)
    else $error("last beat not a closing pixel byte");

endmodule

bind clipped_rect_fill_stream_unit crf_checker u_crf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
